// ===== src/assert_macros.svh =====
// Assertion macros shared by the countdown timer RTL.
// Every macro samples on clk and is off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define PCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pct_pkg.sv =====
// Shared types, constants and the preset table of the countdown timer.
// No dependencies; imported by every module of the block.
package pct_pkg;

	localparam int PRESET_COUNT = 8;
	localparam int PRESET_W     = 3;
	localparam int TIME_W       = 22;
	localparam int MS_W         = 32;
	localparam int LIMIT_W      = 4;
	localparam int GAP_W        = 16;
	localparam int ADDR_W       = 4;
	localparam int DATA_W       = 32;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RUN,
		PH_PAUSED,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		MODE_TICK,
		MODE_SELECT,
		MODE_NEXT,
		MODE_ENTER
	} mode_t;

	typedef enum logic [1:0] {
		CUE_NONE,
		CUE_BLINK,
		CUE_CELEBRATE,
		CUE_PULSE
	} cue_t;

	// Register indexes (word address bits).
	localparam logic [1:0] REG_PULSE_LIMIT = 2'd0;
	localparam logic [1:0] REG_PULSE_GAP   = 2'd1;
	localparam logic [1:0] REG_REDRAW_GAP  = 2'd2;

	localparam logic [LIMIT_W-1:0]  PULSE_LIMIT_RESET = 4'd4;
	localparam logic [GAP_W-1:0]    PULSE_GAP_RESET   = 16'd900;
	localparam logic [GAP_W-1:0]    REDRAW_GAP_RESET  = 16'd250;
	localparam logic [PRESET_W-1:0] PRESET_RESET      = 3'd2;

	typedef struct packed {
		logic [LIMIT_W-1:0] pulse_limit;
		logic [GAP_W-1:0]   pulse_gap;
		logic [GAP_W-1:0]   redraw_gap;
	} cfg_t;

	typedef struct packed {
		cue_t                cue;
		logic                redraw;
		phase_t              phase;
		logic [TIME_W-1:0]   remaining;
		logic [PRESET_W-1:0] preset;
	} result_t;

	// Preset durations in ms: 1, 3, 5, 10, 15, 25, 45, 60 minutes.
	function automatic logic [TIME_W-1:0] preset_ms(input logic [PRESET_W-1:0] idx);
		logic [TIME_W-1:0] ms;
		unique case (idx)
			3'd0: ms = 22'd60000;
			3'd1: ms = 22'd180000;
			3'd2: ms = 22'd300000;
			3'd3: ms = 22'd600000;
			3'd4: ms = 22'd900000;
			3'd5: ms = 22'd1500000;
			3'd6: ms = 22'd2700000;
			3'd7: ms = 22'd3600000;
		endcase
		return ms;
	endfunction

endpackage

// ===== src/pct_cfg_regs.sv =====
// APB-style configuration registers of the countdown timer.
// Depends on pct_pkg for the register indexes and the cfg_t bundle.
module pct_cfg_regs (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [pct_pkg::ADDR_W-1:0] paddr,
	input  logic [pct_pkg::DATA_W-1:0] pwdata,
	output logic [pct_pkg::DATA_W-1:0] prdata,
	output logic                    pready,
	output pct_pkg::cfg_t           cfg
);
	import pct_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_limit <= PULSE_LIMIT_RESET;
			cfg_q.pulse_gap   <= PULSE_GAP_RESET;
			cfg_q.redraw_gap  <= REDRAW_GAP_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PULSE_LIMIT: cfg_q.pulse_limit <= pwdata[LIMIT_W-1:0];
				REG_PULSE_GAP:   cfg_q.pulse_gap   <= pwdata[GAP_W-1:0];
				REG_REDRAW_GAP:  cfg_q.redraw_gap  <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_PULSE_LIMIT: prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_q.pulse_limit};
			REG_PULSE_GAP:   prdata = {{(DATA_W-GAP_W){1'b0}}, cfg_q.pulse_gap};
			REG_REDRAW_GAP:  prdata = {{(DATA_W-GAP_W){1'b0}}, cfg_q.redraw_gap};
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== src/pct_core.sv =====
// Timer state and the per-event update: phase, preset, countdown and due clock.
// Depends on pct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pct_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_fire,
	input  pct_pkg::mode_t          mode,
	input  logic [pct_pkg::MS_W-1:0] now_ms,
	input  pct_pkg::cfg_t           cfg,
	output pct_pkg::result_t        res
);
	import pct_pkg::*;

	phase_t              phase_q, phase_d;
	logic [PRESET_W-1:0] preset_q, preset_d;
	logic [TIME_W-1:0]   time_left_q, time_left_d;
	logic [MS_W-1:0]     last_tick_q, last_tick_d;
	logic                tick_seen_q, tick_seen_d;
	logic [LIMIT_W-1:0]  pulses_q, pulses_d;
	logic [MS_W-1:0]     last_due_q, last_due_d;

	logic [MS_W-1:0]     dt;
	logic [MS_W-1:0]     since_due;
	logic [GAP_W-1:0]    gap_sel;
	logic                expire;
	logic                due;
	logic                pulse_ok;
	logic [PRESET_W:0]   preset_inc;
	logic [PRESET_W-1:0] preset_adv;

	// First tick after reset or enter counts as zero elapsed time.
	assign dt        = tick_seen_q ? (now_ms - last_tick_q) : '0;
	assign expire    = {{(MS_W-TIME_W){1'b0}}, time_left_q} <= dt;
	assign gap_sel   = (phase_q == PH_RUN) ? cfg.redraw_gap : cfg.pulse_gap;
	assign since_due = now_ms - last_due_q;
	assign due       = since_due >= {{(MS_W-GAP_W){1'b0}}, gap_sel};
	assign pulse_ok  = (phase_q == PH_DONE) && (pulses_q < cfg.pulse_limit) && due;

	assign preset_inc = {1'b0, preset_q} + 1'b1;
	assign preset_adv = (int'(preset_inc) >= PRESET_COUNT) ? '0 : preset_inc[PRESET_W-1:0];

	// Next state
	always_comb begin
		phase_d     = phase_q;
		preset_d    = preset_q;
		time_left_d = time_left_q;
		last_tick_d = last_tick_q;
		tick_seen_d = tick_seen_q;
		pulses_d    = pulses_q;
		last_due_d  = last_due_q;
		unique case (mode)
			MODE_TICK: begin
				last_tick_d = now_ms;
				tick_seen_d = 1'b1;
				if (phase_q == PH_RUN) begin
					if (expire) begin
						time_left_d = '0;
						phase_d     = PH_DONE;
						pulses_d    = '0;
					end else begin
						time_left_d = time_left_q - dt[TIME_W-1:0];
					end
					if (due) begin
						last_due_d = now_ms;
					end
				end else if (pulse_ok) begin
					pulses_d   = pulses_q + 1'b1;
					last_due_d = now_ms;
				end
			end
			MODE_SELECT: begin
				unique case (phase_q)
					PH_IDLE:   phase_d = PH_RUN;
					PH_RUN:    phase_d = PH_PAUSED;
					PH_PAUSED: phase_d = PH_RUN;
					PH_DONE: begin
						phase_d     = PH_IDLE;
						time_left_d = preset_ms(preset_q);
					end
				endcase
			end
			MODE_NEXT: begin
				if (phase_q == PH_IDLE) begin
					preset_d    = preset_adv;
					time_left_d = preset_ms(preset_adv);
				end else begin
					phase_d     = PH_IDLE;
					time_left_d = preset_ms(preset_q);
				end
			end
			MODE_ENTER: begin
				phase_d     = PH_IDLE;
				preset_d    = PRESET_RESET;
				time_left_d = preset_ms(PRESET_RESET);
				last_tick_d = '0;
				tick_seen_d = 1'b0;
				pulses_d    = '0;
			end
		endcase
	end

	// Result of the event
	always_comb begin
		res.cue       = CUE_NONE;
		res.redraw    = 1'b0;
		res.phase     = phase_d;
		res.remaining = time_left_d;
		res.preset    = preset_d;
		unique case (mode)
			MODE_TICK: begin
				if (phase_q == PH_RUN) begin
					res.cue    = expire ? CUE_CELEBRATE : CUE_NONE;
					res.redraw = due;
				end else if (pulse_ok) begin
					res.cue    = CUE_PULSE;
					res.redraw = 1'b1;
				end
			end
			MODE_SELECT: begin
				res.cue    = CUE_BLINK;
				res.redraw = 1'b1;
			end
			MODE_NEXT:  res.redraw = 1'b1;
			MODE_ENTER: res.redraw = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			preset_q    <= PRESET_RESET;
			time_left_q <= preset_ms(PRESET_RESET);
			last_tick_q <= '0;
			tick_seen_q <= 1'b0;
			pulses_q    <= '0;
			last_due_q  <= '0;
		end else if (item_fire) begin
			phase_q     <= phase_d;
			preset_q    <= preset_d;
			time_left_q <= time_left_d;
			last_tick_q <= last_tick_d;
			tick_seen_q <= tick_seen_d;
			pulses_q    <= pulses_d;
			last_due_q  <= last_due_d;
		end
	end

	`PCT_ASSERT_NEXT(a_enter_restarts, item_fire && (mode == MODE_ENTER), (phase_q == PH_IDLE) && (preset_q == PRESET_RESET) && !tick_seen_q, "enter did not restart the timer")
	`PCT_ASSERT_NOW(a_done_is_zero, phase_q == PH_DONE, time_left_q == '0, "done phase with time left")
	`PCT_ASSERT_NEXT(a_paused_tick_holds, item_fire && (mode == MODE_TICK) && (phase_q == PH_PAUSED), (phase_q == PH_PAUSED) && (time_left_q == $past(time_left_q)), "tick changed a paused countdown")

endmodule

// ===== src/preset_countdown_timer_unit.sv =====
// An accepted input beat passes the input register, then the state update and the result
// register, to become its result beat. Throughput: one event per cycle while the result
// register is not held by result_stall, set by the state update in pct_core.
// Reset: arst_n clears the timer to idle with the five-minute preset and the
// registers to their defaults; no clearing pass, the block takes beats at once.
// Top level: input register, timer core, result register, configuration registers.
`include "assert_macros.svh"

module preset_countdown_timer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pct_pkg::ADDR_W-1:0]    paddr,
	input  logic [pct_pkg::DATA_W-1:0]    pwdata,
	output logic [pct_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    mode,
	input  logic [pct_pkg::MS_W-1:0]      now_ms,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [1:0]                    cue_event,
	output logic                          redraw,
	output logic [1:0]                    phase_now,
	output logic [pct_pkg::TIME_W-1:0]    remaining_ms,
	output logic [pct_pkg::PRESET_W-1:0]  preset_now
);
	import pct_pkg::*;

	cfg_t            cfg;
	result_t         res;
	logic            valid_s1;
	mode_t           mode_s1;
	logic [MS_W-1:0] now_ms_s1;
	logic            valid_s2;
	result_t         res_s2;
	logic            out_free;
	logic            fire;

	pct_cfg_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	pct_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_fire(fire),
		.mode     (mode_s1),
		.now_ms   (now_ms_s1),
		.cfg      (cfg),
		.res      (res)
	);

	assign out_free   = !valid_s2 || !result_stall;
	assign fire       = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	// Input register: hold the beat while the result register is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			mode_s1   <= mode_t'(mode);
			now_ms_s1 <= now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res;
		end
	end

	assign result_valid = valid_s2;
	assign cue_event    = res_s2.cue;
	assign redraw       = res_s2.redraw;
	assign phase_now    = res_s2.phase;
	assign remaining_ms = res_s2.remaining;
	assign preset_now   = res_s2.preset;

	`PCT_ASSERT_NEXT(a_fire_fills_out, fire, valid_s2, "processed beat missing at result register")
	`PCT_ASSERT_NEXT(a_blocked_holds, valid_s1 && valid_s2 && result_stall, valid_s1 && $stable(now_ms_s1), "input beat lost while result blocked")
	`PCT_ASSERT_NEXT(a_time_in_range, fire, remaining_ms <= 22'd3600000, "remaining time above the longest preset")

endmodule

// ===== tb/preset_countdown_timer_unit_tb.sv =====
// Self-checking bench for preset_countdown_timer_unit: directed table, then phased random events.
// Uses pct_pkg for enums, widths, register indexes and reset values; predicts every result beat.
module preset_countdown_timer_unit_tb;
	import pct_pkg::*;

	localparam int DIR_N       = 27;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 200;
	localparam int SETTLE      = 4;
	localparam int HOLD_CYCLES = 120;
	localparam int SHOW_MAX    = 10;

	typedef struct {
		mode_t             md;
		logic [MS_W-1:0]   now;
		bit                typed;
		result_t           res;
	} dir_row_t;

	localparam result_t NO_RES = '0;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_W-1:0]    paddr;
	logic [DATA_W-1:0]    pwdata;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	logic                 item_valid;
	logic                 item_stall;
	logic [1:0]           mode;
	logic [MS_W-1:0]      now_ms;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [1:0]           cue_event;
	logic                 redraw;
	logic [1:0]           phase_now;
	logic [TIME_W-1:0]    remaining_ms;
	logic [PRESET_W-1:0]  preset_now;

	// Timer model state and register copies.
	phase_t               tm_phase;
	logic [PRESET_W-1:0]  tm_preset;
	logic [TIME_W-1:0]    tm_left;
	logic [MS_W-1:0]      tm_last_tick;
	bit                   tm_seen;
	logic [LIMIT_W-1:0]   tm_pulses;
	logic [MS_W-1:0]      tm_last_due;
	logic [LIMIT_W-1:0]   cfg_limit;
	logic [GAP_W-1:0]     cfg_pulse_gap;
	logic [GAP_W-1:0]     cfg_redraw_gap;

	result_t              pending_q[$];
	result_t              seen;
	int                   err_count = 0;
	int                   idle_pct  = 0;
	int                   stall_pct = 0;
	int                   hold_req  = 0;
	int                   hold_seen = 0;
	int                   hold_left = 0;
	logic [MS_W-1:0]      stim_now  = '0;

	dir_row_t dir_tab [DIR_N] = '{
		'{MODE_NEXT,   32'd0,          1'b1, '{CUE_NONE, 1'b1, PH_IDLE, 22'd600000, 3'd3}},
		'{MODE_ENTER,  32'd0,          1'b1, '{CUE_NONE, 1'b1, PH_IDLE, 22'd300000, 3'd2}},
		'{MODE_TICK,   32'd0,          1'b1, '{CUE_NONE, 1'b0, PH_IDLE, 22'd300000, 3'd2}},
		'{MODE_NEXT,   32'hFFFFFFFF,   1'b0, NO_RES},
		'{MODE_NEXT,   32'd0,          1'b0, NO_RES},
		'{MODE_NEXT,   32'd0,          1'b0, NO_RES},
		'{MODE_NEXT,   32'd0,          1'b0, NO_RES},
		'{MODE_NEXT,   32'd0,          1'b0, NO_RES},
		'{MODE_NEXT,   32'd0,          1'b0, NO_RES},
		'{MODE_SELECT, 32'd0,          1'b0, NO_RES},
		'{MODE_TICK,   32'd0,          1'b0, NO_RES},
		'{MODE_TICK,   32'd59999,      1'b0, NO_RES},
		'{MODE_SELECT, 32'd0,          1'b0, NO_RES},
		'{MODE_TICK,   32'd100000,     1'b0, NO_RES},
		'{MODE_SELECT, 32'd0,          1'b0, NO_RES},
		'{MODE_TICK,   32'hFFFFFFFF,   1'b0, NO_RES},
		'{MODE_TICK,   32'd0,          1'b0, NO_RES},
		'{MODE_TICK,   32'd900,        1'b0, NO_RES},
		'{MODE_TICK,   32'd1800,       1'b0, NO_RES},
		'{MODE_TICK,   32'd2700,       1'b0, NO_RES},
		'{MODE_TICK,   32'd3600,       1'b0, NO_RES},
		'{MODE_TICK,   32'd9000,       1'b0, NO_RES},
		'{MODE_SELECT, 32'd0,          1'b0, NO_RES},
		'{MODE_SELECT, 32'd0,          1'b0, NO_RES},
		'{MODE_NEXT,   32'd0,          1'b0, NO_RES},
		'{MODE_ENTER,  32'hFFFFFFFF,   1'b1, '{CUE_NONE, 1'b1, PH_IDLE, 22'd300000, 3'd2}},
		'{MODE_TICK,   32'hFFFFFFFF,   1'b1, '{CUE_NONE, 1'b0, PH_IDLE, 22'd300000, 3'd2}}
	};

	preset_countdown_timer_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.now_ms       (now_ms),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cue_event    (cue_event),
		.redraw       (redraw),
		.phase_now    (phase_now),
		.remaining_ms (remaining_ms),
		.preset_now   (preset_now)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [TIME_W-1:0] preset_len(input logic [PRESET_W-1:0] idx);
		int minutes;
		case (idx)
			3'd0: minutes = 1;
			3'd1: minutes = 3;
			3'd2: minutes = 5;
			3'd3: minutes = 10;
			3'd4: minutes = 15;
			3'd5: minutes = 25;
			3'd6: minutes = 45;
			default: minutes = 60;
		endcase
		return TIME_W'(minutes * 60000);
	endfunction

	// Shared due clock for redraw and pulse spacing; advance it when due.
	function automatic bit due_now(input logic [MS_W-1:0] t, input logic [GAP_W-1:0] gap);
		logic [MS_W-1:0] since;
		since = t - tm_last_due;
		if (since >= {16'd0, gap}) begin
			tm_last_due = t;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic timer_restart();
		tm_phase     = PH_IDLE;
		tm_preset    = PRESET_RESET;
		tm_left      = preset_len(PRESET_RESET);
		tm_last_tick = '0;
		tm_seen      = 1'b0;
		tm_pulses    = '0;
	endtask

	task automatic timer_step(input mode_t md, input logic [MS_W-1:0] t, output result_t r);
		logic [MS_W-1:0] dt;
		cue_t            cue;
		logic            rd;
		cue = CUE_NONE;
		rd  = 1'b0;
		case (md)
			MODE_TICK: begin
				if (!tm_seen) begin
					tm_last_tick = t;
					tm_seen      = 1'b1;
				end
				dt           = t - tm_last_tick;
				tm_last_tick = t;
				if (tm_phase == PH_RUN) begin
					if ({10'd0, tm_left} <= dt) begin
						tm_left   = '0;
						tm_phase  = PH_DONE;
						tm_pulses = '0;
						cue       = CUE_CELEBRATE;
					end else begin
						tm_left = tm_left - dt[TIME_W-1:0];
					end
					rd = due_now(t, cfg_redraw_gap);
				end else if (tm_phase == PH_DONE && tm_pulses < cfg_limit) begin
					if (due_now(t, cfg_pulse_gap)) begin
						tm_pulses = tm_pulses + 1'b1;
						cue       = CUE_PULSE;
						rd        = 1'b1;
					end
				end
			end
			MODE_SELECT: begin
				case (tm_phase)
					PH_IDLE:   tm_phase = PH_RUN;
					PH_RUN:    tm_phase = PH_PAUSED;
					PH_PAUSED: tm_phase = PH_RUN;
					default: begin
						tm_phase = PH_IDLE;
						tm_left  = preset_len(tm_preset);
					end
				endcase
				cue = CUE_BLINK;
				rd  = 1'b1;
			end
			MODE_NEXT: begin
				if (tm_phase == PH_IDLE)
					tm_preset = PRESET_W'((tm_preset + 1) % PRESET_COUNT);
				else
					tm_phase = PH_IDLE;
				tm_left = preset_len(tm_preset);
				rd      = 1'b1;
			end
			default: begin
				timer_restart();
				rd = 1'b1;
			end
		endcase
		r.cue       = cue;
		r.redraw    = rd;
		r.phase     = tm_phase;
		r.remaining = tm_left;
		r.preset    = tm_preset;
	endtask

	task automatic flag_error(input string msg);
		err_count++;
		if (err_count <= SHOW_MAX)
			$display("%0t: %s", $realtime, msg);
	endtask

	task automatic send_event(input mode_t md, input logic [MS_W-1:0] t, input bit typed,
			input result_t res);
		result_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		mode       <= md;
		now_ms     <= t;
		do @(posedge clk); while (item_stall);
		timer_step(md, t, r);
		pending_q.push_back(typed ? res : r);
	endtask

	// Drop valid, wait for every pending beat, then let the pipe settle.
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
		logic [DATA_W-1:0] want;
		case (idx)
			REG_PULSE_LIMIT: want = {28'd0, val[LIMIT_W-1:0]};
			REG_PULSE_GAP:   want = {16'd0, val[GAP_W-1:0]};
			default:         want = {16'd0, val[GAP_W-1:0]};
		endcase
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		// read back
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== want)
			flag_error($sformatf("register %0d readback: exp %0h got %0h", idx, want, prdata));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_PULSE_LIMIT: cfg_limit = val[LIMIT_W-1:0];
			REG_PULSE_GAP:   cfg_pulse_gap = val[GAP_W-1:0];
			default:         cfg_redraw_gap = val[GAP_W-1:0];
		endcase
	endtask

	// Mostly a plausible tick stream with buttons mixed in; some jumps and exact expiries.
	task automatic random_event(output mode_t md, output logic [MS_W-1:0] t);
		int              r;
		int              s;
		logic [MS_W-1:0] d;
		r = $urandom_range(0, 99);
		if (r < 78) begin
			md = MODE_TICK;
			s  = $urandom_range(0, 99);
			d  = '0;
			if (s < 60)
				d = $urandom_range(0, 1500);
			else if (s < 75)
				d = $urandom_range(0, 70000);
			else if (s < 87)
				d = tm_left + $urandom_range(0, 2) - 1;
			else if (s < 93)
				stim_now = $urandom;
			stim_now = stim_now + d;
			t        = stim_now;
		end else begin
			if (r < 88)
				md = MODE_SELECT;
			else if (r < 95)
				md = MODE_NEXT;
			else
				md = MODE_ENTER;
			t = $urandom;
		end
	endtask

	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_q.size() == 0) begin
				flag_error($sformatf("unexpected beat: cue %0d rd %0d ph %0d left %0d pre %0d",
					cue_event, redraw, phase_now, remaining_ms, preset_now));
			end else begin
				seen = pending_q.pop_front();
				if (cue_event !== seen.cue || redraw !== seen.redraw ||
						phase_now !== seen.phase || remaining_ms !== seen.remaining ||
						preset_now !== seen.preset)
					flag_error($sformatf({"mismatch: exp cue %0d rd %0d ph %0d left %0d pre %0d",
						" / got cue %0d rd %0d ph %0d left %0d pre %0d"},
						seen.cue, seen.redraw, seen.phase, seen.remaining, seen.preset,
						cue_event, redraw, phase_now, remaining_ms, preset_now));
			end
		end
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		mode_t           md;
		logic [MS_W-1:0] t;
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		item_valid = 1'b0;
		mode       = MODE_TICK;
		now_ms     = '0;
		cfg_limit      = PULSE_LIMIT_RESET;
		cfg_pulse_gap  = PULSE_GAP_RESET;
		cfg_redraw_gap = REDRAW_GAP_RESET;
		tm_last_due    = '0;
		timer_restart();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_N; i++)
			send_event(dir_tab[i].md, dir_tab[i].now, dir_tab[i].typed, dir_tab[i].res);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				1: begin
					reg_write(REG_PULSE_LIMIT, 32'd15);
					reg_write(REG_PULSE_GAP, 32'd0);
					reg_write(REG_REDRAW_GAP, 32'd0);
				end
				2: begin
					reg_write(REG_PULSE_LIMIT, 32'd0);
					reg_write(REG_PULSE_GAP, 32'hFFFF);
					reg_write(REG_REDRAW_GAP, 32'hFFFF);
				end
				4: begin
					reg_write(REG_PULSE_LIMIT, 32'd15);
					reg_write(REG_PULSE_GAP, 32'hFFFF);
					reg_write(REG_REDRAW_GAP, 32'd0);
				end
				5: begin
					reg_write(REG_PULSE_LIMIT, 32'd1);
					reg_write(REG_PULSE_GAP, 32'd0);
					reg_write(REG_REDRAW_GAP, 32'hFFFF);
				end
				3, 6, 7: begin
					reg_write(REG_PULSE_LIMIT, $urandom);
					reg_write(REG_PULSE_GAP, ($urandom & 32'hFFFF0000) | $urandom_range(0, 3000));
					reg_write(REG_REDRAW_GAP, ($urandom & 32'hFFFF0000) | $urandom_range(0, 1000));
				end
				default: ;
			endcase
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 54; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 54; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					drain();
				// long receiver hold while the sender keeps pushing
				if (p == 4 && n == 20)
					hold_req++;
				random_event(md, t);
				send_event(md, t, 1'b0, NO_RES);
			end
			drain();
		end

		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
